/* hw/rtl/bbfh_pkg.sv */
// bump/best-fit heap allocator: shared types, codes and defaults
`timescale 1ns / 1ps
package bbfh_pkg;

  localparam int DEF_USED_DEPTH = 64;
  localparam int DEF_HOLE_DEPTH = 64;
  localparam int DEF_ALIGN      = 8;

  // width of the alignment datapath (sums of two 32-bit values plus rounding)
  localparam int XW = 35;

  localparam logic [31:0] RST_HEAP_START = 32'd1024;
  localparam logic [31:0] RST_MAX_MEM    = 32'hFFFF_FFFF;
  localparam logic [31:0] RST_INIT_MEM   = 32'd2097152;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_LIMIT    = 3'd2;
  localparam logic [2:0] ST_NOTALLOC = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic [1:0] CFG_HEAP_START = 2'd0;
  localparam logic [1:0] CFG_MAX_MEM    = 2'd1;
  localparam logic [1:0] CFG_INIT_MEM   = 2'd2;

  typedef struct packed {
    logic        action;
    logic [31:0] request_size;
    logic [31:0] chunk_address;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted_address;
    logic [31:0] chunk_bytes;
    logic [31:0] memory_bytes;
    logic [6:0]  used_entries;
    logic [6:0]  free_entries;
  } result_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } entry_t;

  typedef struct packed {
    logic [31:0] heap_start;
    logic [31:0] max_mem;
    logic [31:0] init_mem;
  } cfg_t;

endpackage

/* hw/rtl/bump_best_fit_heap_allocator.sv */
// heap allocator top level: configuration registers and result register
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------
//  in       | in_valid / in_ready   | in_data  (bbfh_pkg::item_t)
//  out      | out_valid / out_ready | out_data (bbfh_pkg::result_t)
//  cfg      | cfg_write             | cfg_index, cfg_data
//
// one request at a time; an allocate served at the bump pointer takes one
// alignment plus a used-table slot search, best fit adds an alignment of the
// size and one hole table pass, growth one more alignment. a free takes one
// used-table lookup pass, then one hole pass per merge round plus a final
// pass; table read port sets the pace.
// alignment by a non power of two runs a longer register pipeline than a mask.
// after reset the init state loads bump pointer and memory size from the registers.
// a finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
module bump_best_fit_heap_allocator #(
  parameter int USED_TABLE_DEPTH = bbfh_pkg::DEF_USED_DEPTH,
  parameter int HOLE_TABLE_DEPTH = bbfh_pkg::DEF_HOLE_DEPTH,
  parameter int ALIGN_BYTES      = bbfh_pkg::DEF_ALIGN
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bbfh_pkg::item_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bbfh_pkg::result_t out_data,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  bbfh_pkg::cfg_t    cfg;
  bbfh_pkg::result_t res;
  logic              res_valid;
  logic              res_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heap_start <= bbfh_pkg::RST_HEAP_START;
      cfg.max_mem    <= bbfh_pkg::RST_MAX_MEM;
      cfg.init_mem   <= bbfh_pkg::RST_INIT_MEM;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bbfh_pkg::CFG_HEAP_START: cfg.heap_start <= cfg_data;
        bbfh_pkg::CFG_MAX_MEM:    cfg.max_mem    <= cfg_data;
        bbfh_pkg::CFG_INIT_MEM:   cfg.init_mem   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res_take) begin
      out_data <= res;
    end
  end

  bbfh_engine #(
    .USED_TABLE_DEPTH (USED_TABLE_DEPTH),
    .HOLE_TABLE_DEPTH (HOLE_TABLE_DEPTH),
    .ALIGN_BYTES      (ALIGN_BYTES)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (in_valid),
    .item_ready (in_ready),
    .item       (in_data),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

endmodule

/* hw/rtl/bbfh_table.sv */
// chunk table memory: one write port, one registered read port
`timescale 1ns / 1ps
module bbfh_table #(
  parameter int DEPTH = bbfh_pkg::DEF_USED_DEPTH
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  bbfh_pkg::entry_t         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output bbfh_pkg::entry_t         rdata
);

  bbfh_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/bbfh_align.sv */
// round-up-to-alignment unit: mask for powers of two, folded remainder otherwise
`timescale 1ns / 1ps
module bbfh_align #(
  parameter int ALIGN_BYTES = bbfh_pkg::DEF_ALIGN
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [bbfh_pkg::XW-1:0] x,
  output logic                    done,
  output logic [bbfh_pkg::XW-1:0] y
);

  localparam int XW = bbfh_pkg::XW;

  if ((ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0) begin : g_mask
    localparam logic [XW-1:0] ADD = XW'(ALIGN_BYTES - 1);

    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= start;
      end
      y <= (x + ADD) & ~ADD;
    end
  end else begin : g_fold
    localparam int SBW = 17;
    localparam int SH  = 24;
    localparam logic [SBW-1:0] AL  = SBW'(ALIGN_BYTES);
    localparam logic [22:0]    MUL = 23'((64'd1 << SH) / ALIGN_BYTES);
    localparam logic [SBW-1:0] W0  = SBW'(1 % ALIGN_BYTES);
    localparam logic [SBW-1:0] W1  = SBW'((64'd1 << 8) % ALIGN_BYTES);
    localparam logic [SBW-1:0] W2  = SBW'((64'd1 << 16) % ALIGN_BYTES);
    localparam logic [SBW-1:0] W3  = SBW'((64'd1 << 24) % ALIGN_BYTES);
    localparam logic [SBW-1:0] W4  = SBW'((64'd1 << 32) % ALIGN_BYTES);

    logic            v1;
    logic            v2;
    logic            v3;
    logic [XW-1:0]   xr;
    logic [SBW-1:0]  fold;
    logic [SBW-1:0]  fsum;
    logic [SBW-1:0]  fsum_d;
    logic [SBW+22:0] prod;
    logic [SBW-1:0]  quo;
    logic [SBW-1:0]  r0;
    logic [SBW-1:0]  rem_c;
    logic [SBW-1:0]  rem;

    // byte weights are 256^i mod ALIGN_BYTES, so the folded sum keeps the remainder
    // the reciprocal quotient may come out one low, hence one compare and subtract
    always_comb begin
      fold = SBW'(x[7:0]) * W0 + SBW'(x[15:8]) * W1 + SBW'(x[23:16]) * W2 +
             SBW'(x[31:24]) * W3 + SBW'(x[XW-1:32]) * W4;
      prod = (SBW + 23)'(fsum) * (SBW + 23)'(MUL);
      r0   = fsum_d - quo * AL;
      if (r0 >= AL) begin
        rem_c = r0 - AL;
      end else begin
        rem_c = r0;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v1   <= 1'b0;
        v2   <= 1'b0;
        v3   <= 1'b0;
        done <= 1'b0;
      end else begin
        v1   <= start;
        v2   <= v1;
        v3   <= v2;
        done <= v3;
      end
      if (start) begin
        xr <= x;
      end
      fsum   <= fold;
      fsum_d <= fsum;
      quo    <= prod[SH +: SBW];
      rem    <= rem_c;
      if (rem == '0) begin
        y <= xr;
      end else begin
        y <= xr + XW'(AL - rem);
      end
    end
  end

endmodule

/* hw/rtl/bbfh_engine.sv */
// allocation sequencer: table scans, best fit, merging and bump pointer update
`timescale 1ns / 1ps
module bbfh_engine #(
  parameter int USED_TABLE_DEPTH = bbfh_pkg::DEF_USED_DEPTH,
  parameter int HOLE_TABLE_DEPTH = bbfh_pkg::DEF_HOLE_DEPTH,
  parameter int ALIGN_BYTES      = bbfh_pkg::DEF_ALIGN
) (
  input  logic              clk,
  input  logic              rst,
  input  bbfh_pkg::cfg_t    cfg,
  input  logic              item_valid,
  output logic              item_ready,
  input  bbfh_pkg::item_t   item,
  output logic              res_valid,
  input  logic              res_take,
  output bbfh_pkg::result_t res
);

  localparam int UD  = USED_TABLE_DEPTH;
  localparam int HD  = HOLE_TABLE_DEPTH;
  localparam int UW  = $clog2(UD);
  localparam int HW  = $clog2(HD);
  localparam int IW  = (UW > HW) ? UW : HW;
  localparam int SW  = IW + 1;
  localparam int UCW = $clog2(UD + 1);
  localparam int HCW = $clog2(HD + 1);
  localparam int XW  = bbfh_pkg::XW;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_AEND  = 4'd3;
  localparam logic [3:0] S_ANEED = 4'd4;
  localparam logic [3:0] S_HSCAN = 4'd5;
  localparam logic [3:0] S_AGROW = 4'd6;
  localparam logic [3:0] S_USLOT = 4'd7;
  localparam logic [3:0] S_FSCAN = 4'd8;
  localparam logic [3:0] S_MPASS = 4'd9;
  localparam logic [3:0] S_FFIN  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0]       state;
  bbfh_pkg::item_t  req;
  logic [31:0]      bump;
  logic [31:0]      memsize;
  logic [XW-1:0]    need;
  logic [SW-1:0]    scan;
  logic             pend;
  logic [IW-1:0]    pidx;
  logic [UD-1:0]    used_valid;
  logic [HD-1:0]    hole_valid;
  logic [UCW-1:0]   ucount;
  logic [HCW-1:0]   hcount;
  logic             best_found;
  logic [HW-1:0]    best_idx;
  logic [31:0]      best_start;
  logic [31:0]      best_len;
  logic             found;
  logic [UW-1:0]    u_idx;
  logic [31:0]      u_len;
  logic [31:0]      cs;
  logic [33:0]      cl;
  logic             merged;
  logic             highest;
  logic             hslot_found;
  logic [HW-1:0]    hslot;
  logic [2:0]       res_status;
  logic [31:0]      res_addr;
  logic [31:0]      res_len;
  logic             a_go;
  logic [XW-1:0]    a_x;
  logic             a_done;
  logic [XW-1:0]    a_y;

  bbfh_pkg::entry_t u_rdata;
  bbfh_pkg::entry_t h_rdata;
  logic             u_wen;
  bbfh_pkg::entry_t u_wdata;
  logic             h_wen;
  logic [HW-1:0]    h_waddr;
  bbfh_pkg::entry_t h_wdata;

  logic             u_end;
  logic             h_end;
  logic             split;
  logic             give_back;
  logic [33:0]      fwd_end;
  logic [32:0]      back_end;
  logic [35:0]      grow4;
  logic [35:0]      grow1;
  logic [35:0]      cand;
  logic [UCW+6:0]   ucount_ext;
  logic [HCW+6:0]   hcount_ext;

  bbfh_table #(.DEPTH(UD)) u_used (
    .clk   (clk),
    .wen   (u_wen),
    .waddr (scan[UW-1:0]),
    .wdata (u_wdata),
    .raddr (scan[UW-1:0]),
    .rdata (u_rdata)
  );

  bbfh_table #(.DEPTH(HD)) u_hole (
    .clk   (clk),
    .wen   (h_wen),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (scan[HW-1:0]),
    .rdata (h_rdata)
  );

  bbfh_align #(.ALIGN_BYTES(ALIGN_BYTES)) u_align (
    .clk   (clk),
    .rst   (rst),
    .start (a_go),
    .x     (a_x),
    .done  (a_done),
    .y     (a_y)
  );

  always_comb begin
    u_end     = (scan == SW'(UD)) && !pend;
    h_end     = (scan == SW'(HD)) && !pend;
    split     = {3'b0, best_len} > need;
    fwd_end   = {2'b0, cs} + cl;
    back_end  = {1'b0, h_rdata.start} + {1'b0, h_rdata.length};
    give_back = highest && (fwd_end == {2'b0, bump});
    grow4     = {4'b0, bump} + {need[33:0], 2'b00};
    grow1     = {4'b0, bump} + {1'b0, need};
    if (grow4 < {4'b0, cfg.max_mem}) begin
      cand = grow4;
    end else begin
      cand = grow1;
    end
    if (cand < {1'b0, a_y}) begin
      cand = {1'b0, a_y};
    end

    u_wen   = (state == S_USLOT) && !used_valid[scan[UW-1:0]];
    u_wdata = '{start: res_addr, length: res_len};

    h_wen   = 1'b0;
    h_waddr = best_idx;
    h_wdata = '{start: best_start + need[31:0], length: best_len - need[31:0]};
    if (state == S_HSCAN && h_end && best_found && split) begin
      h_wen = 1'b1;
    end else if (state == S_FFIN && !give_back && hslot_found) begin
      h_wen   = 1'b1;
      h_waddr = hslot;
      h_wdata = '{start: cs, length: cl[31:0]};
    end

    ucount_ext = (UCW + 7)'(ucount);
    hcount_ext = (HCW + 7)'(hcount);
    res.status          = res_status;
    res.granted_address = res_addr;
    res.chunk_bytes     = res_len;
    res.memory_bytes    = memsize;
    res.used_entries    = ucount_ext[6:0];
    res.free_entries    = hcount_ext[6:0];
    res_valid  = (state == S_DONE);
    item_ready = (state == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      pend       <= 1'b0;
      a_go       <= 1'b0;
      used_valid <= '0;
      hole_valid <= '0;
      ucount     <= '0;
      hcount     <= '0;
    end else begin
      a_go <= 1'b0;
      unique case (state)
        S_INIT: begin
          bump    <= cfg.heap_start;
          memsize <= cfg.init_mem;
          state   <= S_IDLE;
        end
        S_IDLE: begin
          if (item_valid) begin
            req   <= item;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          res_addr <= '0;
          res_len  <= '0;
          scan     <= '0;
          pend     <= 1'b0;
          found    <= 1'b0;
          if (req.action == bbfh_pkg::ACT_FREE) begin
            state <= S_FSCAN;
          end else if (req.request_size == '0) begin
            res_status <= bbfh_pkg::ST_ZERO;
            state      <= S_DONE;
          end else if (ucount == UCW'(UD)) begin
            res_status <= bbfh_pkg::ST_FULL;
            state      <= S_DONE;
          end else begin
            a_go  <= 1'b1;
            a_x   <= {3'b0, bump} + {3'b0, req.request_size};
            state <= S_AEND;
          end
        end
        S_AEND: begin
          if (a_done) begin
            if (a_y > {3'b0, cfg.max_mem}) begin
              res_status <= bbfh_pkg::ST_LIMIT;
              state      <= S_DONE;
            end else if (a_y <= {3'b0, memsize}) begin
              bump     <= a_y[31:0];
              res_addr <= bump;
              res_len  <= a_y[31:0] - bump;
              state    <= S_USLOT;
            end else begin
              a_go  <= 1'b1;
              a_x   <= a_y - {3'b0, bump};
              state <= S_ANEED;
            end
          end
        end
        S_ANEED: begin
          if (a_done) begin
            need       <= a_y;
            best_found <= 1'b0;
            state      <= S_HSCAN;
          end
        end
        S_HSCAN: begin
          if (scan != SW'(HD)) begin
            pend <= 1'b1;
            pidx <= scan[IW-1:0];
            scan <= scan + 1'b1;
          end else begin
            pend <= 1'b0;
          end
          // smallest hole that fits, lowest address on a tie
          if (pend && hole_valid[pidx[HW-1:0]] && {3'b0, h_rdata.length} >= need &&
              (!best_found || h_rdata.length < best_len ||
               (h_rdata.length == best_len && h_rdata.start < best_start))) begin
            best_found <= 1'b1;
            best_idx   <= pidx[HW-1:0];
            best_start <= h_rdata.start;
            best_len   <= h_rdata.length;
          end
          if (h_end) begin
            scan <= '0;
            if (best_found) begin
              res_addr <= best_start;
              res_len  <= need[31:0];
              if (!split) begin
                hole_valid[best_idx] <= 1'b0;
                hcount               <= hcount - 1'b1;
              end
              state <= S_USLOT;
            end else if (grow1 > {4'b0, cfg.max_mem}) begin
              res_status <= bbfh_pkg::ST_LIMIT;
              state      <= S_DONE;
            end else begin
              a_go  <= 1'b1;
              a_x   <= grow1[XW-1:0];
              state <= S_AGROW;
            end
          end
        end
        S_AGROW: begin
          if (a_done) begin
            if (a_y > {3'b0, cfg.max_mem}) begin
              res_status <= bbfh_pkg::ST_LIMIT;
              state      <= S_DONE;
            end else begin
              memsize  <= cand[31:0];
              bump     <= a_y[31:0];
              res_addr <= bump;
              res_len  <= a_y[31:0] - bump;
              state    <= S_USLOT;
            end
          end
        end
        S_USLOT: begin
          if (u_wen) begin
            used_valid[scan[UW-1:0]] <= 1'b1;
            ucount                   <= ucount + 1'b1;
            res_status               <= bbfh_pkg::ST_OK;
            state                    <= S_DONE;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_FSCAN: begin
          if (scan != SW'(UD)) begin
            pend <= 1'b1;
            pidx <= scan[IW-1:0];
            scan <= scan + 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend && !found && used_valid[pidx[UW-1:0]] &&
              u_rdata.start == req.chunk_address) begin
            found <= 1'b1;
            u_idx <= pidx[UW-1:0];
            u_len <= u_rdata.length;
          end
          if (u_end) begin
            scan        <= '0;
            cs          <= req.chunk_address;
            cl          <= {2'b0, u_len};
            merged      <= 1'b0;
            highest     <= 1'b1;
            hslot_found <= 1'b0;
            if (found) begin
              state <= S_MPASS;
            end else begin
              res_status <= bbfh_pkg::ST_NOTALLOC;
              state      <= S_DONE;
            end
          end
        end
        S_MPASS: begin
          if (scan != SW'(HD)) begin
            pend <= 1'b1;
            pidx <= scan[IW-1:0];
            scan <= scan + 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (hole_valid[pidx[HW-1:0]] && {2'b0, h_rdata.start} == fwd_end) begin
              cl                       <= cl + {2'b0, h_rdata.length};
              hole_valid[pidx[HW-1:0]] <= 1'b0;
              hcount                   <= hcount - 1'b1;
              merged                   <= 1'b1;
            end else if (hole_valid[pidx[HW-1:0]] && back_end == {1'b0, cs}) begin
              cs                       <= h_rdata.start;
              cl                       <= cl + {2'b0, h_rdata.length};
              hole_valid[pidx[HW-1:0]] <= 1'b0;
              hcount                   <= hcount - 1'b1;
              merged                   <= 1'b1;
            end else begin
              // only meaningful on a pass that merges nothing
              if (hole_valid[pidx[HW-1:0]] && h_rdata.start > cs) begin
                highest <= 1'b0;
              end
              if (!hole_valid[pidx[HW-1:0]] && !hslot_found) begin
                hslot_found <= 1'b1;
                hslot       <= pidx[HW-1:0];
              end
            end
          end
          if (h_end) begin
            scan        <= '0;
            merged      <= 1'b0;
            highest     <= 1'b1;
            hslot_found <= 1'b0;
            if (!merged) begin
              highest     <= highest;
              hslot_found <= hslot_found;
              state       <= S_FFIN;
            end
          end
        end
        S_FFIN: begin
          if (give_back || hslot_found) begin
            if (give_back) begin
              bump <= cs;
            end else begin
              hole_valid[hslot] <= 1'b1;
              hcount            <= hcount + 1'b1;
            end
            used_valid[u_idx] <= 1'b0;
            ucount            <= ucount - 1'b1;
            res_len           <= u_len;
            res_status        <= bbfh_pkg::ST_OK;
          end else begin
            res_status <= bbfh_pkg::ST_FULL;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_used_count: assert property (@(posedge clk) disable iff (rst)
    ucount == UCW'($countones(used_valid)))
    else $error("used entry count out of step with valid bits");

  a_hole_count: assert property (@(posedge clk) disable iff (rst)
    hcount == HCW'($countones(hole_valid)))
    else $error("hole count out of step with valid bits");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_status != bbfh_pkg::ST_OK) |-> (res_addr == '0 && res_len == '0))
    else $error("failed request reports an address or size");

  a_pend_scan: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_HSCAN || state == S_FSCAN || state == S_MPASS))
    else $error("read data pending outside a table scan");

endmodule
